[rtl/kcrr_pkg.sv]
// shared types and constants for the key chord release reporter
`default_nettype none

package kcrr_pkg;

    // number of buttons that are taken; higher indexes are dropped
    localparam int MAX_BUTTONS = 16;
    // entries of the held list
    localparam int LIST_DEPTH  = 16;

    localparam int BTN_W  = 4;
    localparam int SLOT_W = 8;
    localparam int BTN_CNT = 2 ** BTN_W;
    localparam int IDX_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = IDX_W + 1;

    typedef logic [BTN_W-1:0]  btn_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic {
        OP_PRESS,
        OP_RELEASE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        btn_t    button;
        slot_t   slot;
    } cmd_t;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPORT,
        ST_SHIFT
    } back_state_t;

endpackage

`default_nettype wire

[rtl/kcrr_front.sv]
// front end: takes button samples, drops out-of-range ones, forms commands
`default_nettype none

module kcrr_front (
    input  wire logic           start,
    input  wire logic           q_full,
    input  wire kcrr_pkg::btn_t  button_index,
    input  wire logic           pressed,
    input  wire kcrr_pkg::slot_t macro_slot,
    output logic                busy,
    output logic                push,
    output kcrr_pkg::cmd_t      cmd
);
    import kcrr_pkg::*;

    logic in_range;

    // accept while the queue has room
    assign busy = q_full;

    // classify the sample
    assign in_range = (int'(button_index) < MAX_BUTTONS);
    assign push     = start && !q_full && in_range;

    always_comb
    begin
        cmd.op     = pressed ? OP_PRESS : OP_RELEASE;
        cmd.button = button_index;
        cmd.slot   = macro_slot;
    end

endmodule

`default_nettype wire

[rtl/kcrr_queue.sv]
// two-entry command queue between front and back end
`default_nettype none

module kcrr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire kcrr_pkg::cmd_t    push_cmd,
    input  wire logic              pop,
    output kcrr_pkg::cmd_t         pop_cmd,
    output kcrr_pkg::q_status_t    status
);
    import kcrr_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign status.empty = (fill_reg == 2'd0);
    assign status.full  = (fill_reg == 2'd2);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/kcrr_back.sv]
// back end: keeps the held list, reports chords and closes up the list
`default_nettype none

module kcrr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kcrr_pkg::q_status_t q_status,
    input  wire kcrr_pkg::cmd_t    cmd,
    output logic                   pop,
    output logic                   result_valid,
    output kcrr_pkg::btn_t         chord_button,
    output kcrr_pkg::slot_t        report_slot,
    output logic                   last_of_chord
);
    import kcrr_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    // held list storage, read data registered
    btn_t        held_mem [LIST_DEPTH];
    btn_t        rd_data_reg;
    logic        rd_en;
    idx_t        rd_addr;
    logic        mem_we;
    idx_t        mem_waddr;
    btn_t        mem_wdata;

    cnt_t        cnt_reg;
    logic        flag_reg;
    logic [BTN_CNT-1:0] listed_reg;
    idx_t        pos_reg [BTN_CNT];

    idx_t        cur_pos_reg;
    btn_t        cur_btn_reg;
    slot_t       slot_reg;
    cnt_t        idx_reg;
    cnt_t        idx_next;
    logic        rd_vld_reg;
    logic        rd_last_reg;
    logic        rd_last_next;
    logic        wr_pend_reg;
    logic        wr_pend_next;
    idx_t        wr_addr_reg;

    logic        do_press;
    logic        do_hit;
    logic        do_report;
    logic        do_finish;
    logic        rep_last;
    cnt_t        idx_inc;

    assign idx_inc  = CNT_W'(idx_reg + 1'b1);
    assign rep_last = (idx_reg == CNT_W'(cnt_reg - 1'b1));

    // next state and control
    always_comb
    begin
        state_next   = state_reg;
        pop          = 1'b0;
        do_press     = 1'b0;
        do_hit       = 1'b0;
        do_report    = 1'b0;
        do_finish    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[IDX_W-1:0];
        rd_last_next = 1'b0;
        wr_pend_next = 1'b0;
        idx_next     = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (cmd.op == OP_PRESS)
                    begin
                        do_press = !listed_reg[cmd.button] &&
                                   (cnt_reg < CNT_W'(LIST_DEPTH));
                    end
                    else if (listed_reg[cmd.button])
                    begin
                        do_hit    = 1'b1;
                        do_report = !((pos_reg[cmd.button] == '0) && flag_reg);
                        if (do_report)
                        begin
                            idx_next   = '0;
                            state_next = ST_REPORT;
                        end
                        else
                        begin
                            idx_next   = {1'b0, pos_reg[cmd.button]};
                            state_next = ST_SHIFT;
                        end
                    end
                end
            end
            ST_REPORT:
            begin
                // one list entry read per cycle, shown the cycle after
                rd_en        = 1'b1;
                rd_addr      = idx_reg[IDX_W-1:0];
                rd_last_next = rep_last;
                if (rep_last)
                begin
                    idx_next   = {1'b0, cur_pos_reg};
                    state_next = ST_SHIFT;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_SHIFT:
            begin
                // read the follower, write it one place down next cycle
                if (idx_inc < cnt_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_inc[IDX_W-1:0];
                    wr_pend_next = 1'b1;
                    idx_next     = idx_inc;
                end
                else
                begin
                    do_finish  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[IDX_W-1:0];
        mem_wdata = cmd.button;
        if (do_press)
        begin
            mem_we = 1'b1;
        end
        else if (wr_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            held_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= held_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            flag_reg    <= 1'b0;
            listed_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= (state_reg == ST_REPORT);
            rd_last_reg <= rd_last_next;
            wr_pend_reg <= wr_pend_next;
            idx_reg     <= idx_next;
            if (do_press)
            begin
                cnt_reg                <= CNT_W'(cnt_reg + 1'b1);
                flag_reg               <= (cnt_reg != '0);
                listed_reg[cmd.button] <= 1'b1;
            end
            if (do_finish)
            begin
                cnt_reg                 <= CNT_W'(cnt_reg - 1'b1);
                listed_reg[cur_btn_reg] <= 1'b0;
            end
        end
    end

    // transaction payload and list positions
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= idx_reg[IDX_W-1:0];
        if (do_hit)
        begin
            cur_pos_reg <= pos_reg[cmd.button];
            cur_btn_reg <= cmd.button;
            slot_reg    <= cmd.slot;
        end
        if (do_press)
        begin
            pos_reg[cmd.button] <= cnt_reg[IDX_W-1:0];
        end
        for (int j = 0; j < BTN_CNT; j++)
        begin
            if (do_finish && listed_reg[j] && (pos_reg[j] > cur_pos_reg))
            begin
                pos_reg[j] <= IDX_W'(pos_reg[j] - 1'b1);
            end
        end
    end

    assign result_valid  = rd_vld_reg;
    assign chord_button  = rd_data_reg;
    assign report_slot   = slot_reg;
    assign last_of_chord = rd_last_reg;

endmodule

`default_nettype wire

[rtl/key_chord_release_reporter.sv]
// key chord release reporter top level
//
//   channel   signals                                        handshake
//   -------   --------------------------------------------   ---------------------
//   sample    button_index, pressed, macro_slot              start high, busy low
//   result    chord_button, report_slot, last_of_chord       result_valid, 1 cycle
//
// a sample is taken into a two-entry queue; busy is high only while it is full.
// the back end takes one sample per cycle from the queue while it is idle; it
// takes no new sample while it reports a chord or closes up the held list after
// a release of a listed button. results come one per cycle and cannot be held
// off.
// reset clears the list count, chord flag, listed bits and queue at once.
`default_nettype none

module key_chord_release_reporter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire kcrr_pkg::btn_t   button_index,
    input  wire logic             pressed,
    input  wire kcrr_pkg::slot_t  macro_slot,
    output logic                  result_valid,
    output kcrr_pkg::btn_t        chord_button,
    output kcrr_pkg::slot_t       report_slot,
    output logic                  last_of_chord
);
    import kcrr_pkg::*;

    logic      q_push;
    logic      q_pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;
    q_status_t q_status;

    // accept and classify
    kcrr_front u_front (
        .start        (start),
        .q_full       (q_status.full),
        .button_index (button_index),
        .pressed      (pressed),
        .macro_slot   (macro_slot),
        .busy         (busy),
        .push         (q_push),
        .cmd          (push_cmd)
    );

    // decoupling queue
    kcrr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // list keeping and reporting
    kcrr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .cmd           (pop_cmd),
        .pop           (q_pop),
        .result_valid  (result_valid),
        .chord_button  (chord_button),
        .report_slot   (report_slot),
        .last_of_chord (last_of_chord)
    );

    // a report ends with a gap before the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_chord) |=> !result_valid)
    else $error("result directly after end of chord");

    // a report runs without gaps and keeps its slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_chord) |=> (result_valid && $stable(report_slot)))
    else $error("chord report broken up");

    // the back end never takes from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

[test/kcrr_chord_checker.sv]
// checker that predicts and compares chord reports of the key chord release reporter
`timescale 1ns / 100ps

module kcrr_chord_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            busy,
    input  wire kcrr_pkg::btn_t  button_index,
    input  wire logic            pressed,
    input  wire kcrr_pkg::slot_t macro_slot,
    input  wire logic            result_valid,
    input  wire kcrr_pkg::btn_t  chord_button,
    input  wire kcrr_pkg::slot_t report_slot,
    input  wire logic            last_of_chord,
    output int                   fail_count,
    output int                   reports_pending
);
    import kcrr_pkg::*;

    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        btn_t  button;
        slot_t slot;
        logic  last;
    } chord_entry_t;

    // predicted state of the held list
    btn_t held_list [LIST_DEPTH];
    int   held_len   = 0;
    logic combo_flag = 1'b0;

    // chord entries still to come out, oldest first
    chord_entry_t chord_reports_q[$];
    int           n_errors = 0;

    // apply one button sample to the held list and queue any chord report
    task automatic update_held_list(input btn_t btn, input logic down, input slot_t slot);
        int pos;
        int i;
        chord_entry_t entry;
        pos = -1;
        if (int'(btn) >= MAX_BUTTONS)
            return;
        for (i = 0; i < held_len; i++)
        begin
            if (pos < 0 && held_list[i] == btn)
                pos = i;
        end
        if (down)
        begin
            // new press goes to the end of the list
            if (pos < 0 && held_len < LIST_DEPTH)
            begin
                held_list[held_len] = btn;
                held_len++;
                combo_flag = (held_len > 1);
            end
            return;
        end
        if (pos < 0)
            return;
        // first button of a combination reports nothing
        if (!(pos == 0 && combo_flag))
        begin
            for (i = 0; i < held_len; i++)
            begin
                entry.button = held_list[i];
                entry.slot   = slot;
                entry.last   = (i == held_len - 1);
                chord_reports_q.insert(chord_reports_q.size(), entry);
            end
        end
        // close up the list behind the released button
        for (i = pos; i + 1 < held_len; i++)
            held_list[i] = held_list[i + 1];
        held_len--;
    endtask

    // compare one chord entry from the block with the oldest prediction
    task automatic check_chord_entry(input btn_t btn, input slot_t slot, input logic last);
        chord_entry_t want;
        if (chord_reports_q.size() == 0)
        begin
            n_errors++;
            if (n_errors <= SHOWN_ERRORS)
                $display("%0t: unexpected chord entry: button %0d slot %0d last %0b",
                         $realtime, btn, slot, last);
            return;
        end
        want = chord_reports_q.pop_front();
        if (want.button !== btn || want.slot !== slot || want.last !== last)
        begin
            n_errors++;
            if (n_errors <= SHOWN_ERRORS)
                $display({"%0t: chord entry mismatch: expected button %0d slot %0d last %0b,",
                          " got button %0d slot %0d last %0b"},
                         $realtime, want.button, want.slot, want.last, btn, slot, last);
        end
    endtask

    // results first: a result never belongs to a sample taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                check_chord_entry(chord_button, report_slot, last_of_chord);
            if (start && !busy)
                update_held_list(button_index, pressed, macro_slot);
        end
        fail_count      <= n_errors;
        reports_pending <= chord_reports_q.size();
    end

endmodule

[test/tb.sv]
// top-level testbench for the key chord release reporter
`timescale 1ns / 100ps

module tb;
    import kcrr_pkg::*;

    localparam int   SAMPLE_COUNT = 410;
    localparam int   CYCLE_LIMIT  = 300000;
    localparam int   DRAIN_CYCLES = 120;
    localparam logic BTN_DOWN     = 1'b1;
    localparam logic BTN_UP       = 1'b0;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    btn_t  button_index;
    logic  pressed;
    slot_t macro_slot;
    logic  result_valid;
    btn_t  chord_button;
    slot_t report_slot;
    logic  last_of_chord;

    int check_failures;
    int reports_pending;
    int cycle_count;

    // sender gaps on or off for the current stretch of samples
    logic idle_on;
    // buttons held as far as the stimulus knows
    logic [BTN_CNT-1:0] held_mask;

    key_chord_release_reporter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .button_index  (button_index),
        .pressed       (pressed),
        .macro_slot    (macro_slot),
        .result_valid  (result_valid),
        .chord_button  (chord_button),
        .report_slot   (report_slot),
        .last_of_chord (last_of_chord)
    );

    kcrr_chord_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .button_index    (button_index),
        .pressed         (pressed),
        .macro_slot      (macro_slot),
        .result_valid    (result_valid),
        .chord_button    (chord_button),
        .report_slot     (report_slot),
        .last_of_chord   (last_of_chord),
        .fail_count      (check_failures),
        .reports_pending (reports_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // one sample transaction: optional gap, then hold start until taken
    task automatic send_sample(input btn_t btn, input logic down, input slot_t slot);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        button_index <= btn;
        pressed      <= down;
        macro_slot   <= slot;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        int    effective;
        int    phase_left;
        int    target;
        int    n_held;
        btn_t  b;
        logic  down;
        slot_t s;

        rst_n        = 1'b0;
        start        = 1'b0;
        button_index = '0;
        pressed      = 1'b0;
        macro_slot   = '0;
        idle_on      = 1'b1;
        held_mask    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single button press and release, slot extremes
        send_sample(4'd0, BTN_DOWN, 8'd0);
        send_sample(4'd0, BTN_UP, 8'd255);
        // two-button chord, then the first button released with the flag set
        send_sample(4'd15, BTN_DOWN, 8'd255);
        send_sample(4'd3, BTN_DOWN, 8'd0);
        send_sample(4'd3, BTN_UP, 8'hAA);
        send_sample(4'd15, BTN_UP, 8'h55);
        // release of a button not held
        send_sample(4'd7, BTN_UP, 8'd1);
        // repeated press, middle release, then first-entry releases
        send_sample(4'd5, BTN_DOWN, 8'd2);
        send_sample(4'd5, BTN_DOWN, 8'd3);
        send_sample(4'd9, BTN_DOWN, 8'd4);
        send_sample(4'd12, BTN_DOWN, 8'd5);
        send_sample(4'd9, BTN_UP, 8'd128);
        send_sample(4'd5, BTN_UP, 8'd127);
        send_sample(4'd12, BTN_UP, 8'd6);
        // a fresh single press clears the flag again
        send_sample(4'd10, BTN_DOWN, 8'd7);
        send_sample(4'd10, BTN_UP, 8'd8);
        // press after a release keeps the flag from the earlier chord
        send_sample(4'd1, BTN_DOWN, 8'd9);
        send_sample(4'd2, BTN_DOWN, 8'd10);
        send_sample(4'd2, BTN_UP, 8'd11);
        send_sample(4'd4, BTN_DOWN, 8'd12);
        send_sample(4'd4, BTN_UP, 8'd13);
        send_sample(4'd1, BTN_UP, 8'd14);

        // random walk over the held set, mostly legal presses and releases
        effective  = 0;
        phase_left = 0;
        target     = 1;
        while (effective < SAMPLE_COUNT)
        begin
            if (phase_left == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    target     = $urandom_range(8, 16);
                    phase_left = $urandom_range(30, 50);
                end
                else
                begin
                    target     = $urandom_range(1, 4);
                    phase_left = $urandom_range(8, 24);
                end
                idle_on = ($urandom_range(0, 2) != 0);
            end
            case ($urandom_range(0, 7))
                0:       s = '0;
                1:       s = '1;
                default: s = slot_t'($urandom_range(0, 255));
            endcase
            b = btn_t'($urandom_range(0, BTN_CNT - 1));
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: press of a held button or release of one not held
                send_sample(b, held_mask[b], s);
                effective++;
            end
            else
            begin
                n_held = $countones(held_mask);
                if (n_held == 0)
                    down = BTN_DOWN;
                else if (n_held == BTN_CNT)
                    down = BTN_UP;
                else if (n_held < target)
                    down = ($urandom_range(0, 3) != 0);
                else
                    down = ($urandom_range(0, 3) == 0);
                while (held_mask[b] == down)
                    b = btn_t'($urandom_range(0, BTN_CNT - 1));
                send_sample(b, down, s);
                held_mask[b] = down;
                effective++;
                phase_left--;
            end
        end
        start <= 1'b0;

        // drain outstanding reports, then watch for stray ones
        @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (check_failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
